// File: hdl/multichannel_moving_average_unit_defines.svh
// Assertion macros used by multichannel_moving_average_unit.sv.
`ifndef MULTICHANNEL_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mma_pkg.sv
`default_nettype none

package mma_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int MAX_CHANNELS = 8;

   localparam int CHANNEL_W    = 3;
   localparam int WINDOW_CFG_W = 7;
   localparam int CHAN_CFG_W   = 4;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 8;

   localparam logic [WINDOW_CFG_W-1:0] WINDOW_RESET = WINDOW_CFG_W'(8);
   localparam logic [CHAN_CFG_W-1:0]   CHAN_RESET   = CHAN_CFG_W'(8);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WINDOW_LENGTH   = CSR_INDEX_W'(0),
      REG_CHANNELS_IN_USE = CSR_INDEX_W'(1)
   } csr_reg_type;

endpackage

`default_nettype wire

// File: hdl/mma_if.sv
`default_nettype none

interface mma_req_if
   import mma_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [CHANNEL_W-1:0]          channel;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                          frame_end;

   modport source (output valid, channel, sample, frame_end, input ready);
   modport sink   (input valid, channel, sample, frame_end, output ready);
endinterface

interface mma_rsp_if
   import mma_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [CHANNEL_W-1:0]          out_channel;
   logic signed [SAMPLE_WIDTH-1:0] average;
   logic                          out_frame_end;

   modport source (output valid, out_channel, average, out_frame_end, input ready);
   modport sink   (input valid, out_channel, average, out_frame_end, output ready);
endinterface

interface mma_csr_if
   import mma_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mma_div.sv
`default_nettype none

module mma_div #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W  = 7,
   parameter int QUOTIENT_W = 16
)(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         negate,
   input  wire logic [DIVIDEND_W-1:0]        dividend,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output logic                              done,
   output logic signed [QUOTIENT_W-1:0]      quotient
);

   localparam int RADIX_BITS = 4;
   localparam int CYCLES     = (DIVIDEND_W + RADIX_BITS - 1) / RADIX_BITS;
   localparam int ACC_W      = CYCLES * RADIX_BITS;
   localparam int CNT_W      = (CYCLES > 1) ? $clog2(CYCLES) : 1;

   logic                  busy_ff;
   logic                  done_ff;
   logic                  neg_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [ACC_W-1:0]      acc_in;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [DIVISOR_W:0]    trial;
   logic [QUOTIENT_W-1:0] mag;

   // Restoring division, several quotient bits per cycle.
   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < RADIX_BITS; i++) begin
         trial  = {rem_in, acc_in[ACC_W-1]};
         acc_in = {acc_in[ACC_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            acc_in[0] = 1'b1;
         end
         rem_in = trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= ACC_W'(dividend);
         rem_ff <= '0;
         den_ff <= divisor;
         neg_ff <= negate;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   assign mag      = acc_ff[QUOTIENT_W-1:0];
   assign quotient = neg_ff ? -mag : mag;
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: hdl/multichannel_moving_average_unit.sv
`default_nettype none
`include "multichannel_moving_average_unit_defines.svh"

// Port     Direction  Carries
// req_bus  in         channel, sample, frame_end
// rsp_bus  out        out_channel, average, out_frame_end
// csr_bus  in         register index and write data
//
// One item is worked on at a time. An item on a channel in use passes through S_READ,
// S_DIV and S_OUT, its average set by the divider, which produces four quotient bits a
// cycle; one on a channel not in use passes through S_READ and S_OUT only.
// Reset is synchronous and clears the sums, the fill count and the write slot.
// After reset and after each configuration write the sample store is cleared entry by
// entry, while neither req_bus nor csr_bus is taken.
// A transaction is taken while a finished result still waits on rsp_bus; a stalled
// rsp_bus holds the block before its next item.

module multichannel_moving_average_unit
   import mma_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
)(
   input wire logic clock,
   input wire logic reset,
   mma_req_if.sink  req_bus,
   mma_rsp_if.source rsp_bus,
   mma_csr_if.sink  csr_bus
);

   localparam int STORE_DEPTH = MAX_WINDOW * MAX_CHANNELS;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CIDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_OUT} state_type;

   state_type state_ff;

   logic [WINDOW_CFG_W-1:0] win_cfg_ff;
   logic [CHAN_CFG_W-1:0]   chan_cfg_ff;
   logic [WIN_W-1:0]        win_eff;
   logic [CHN_W-1:0]        chan_eff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [WIN_W-1:0]        slot_plus;
   logic [WIN_W-1:0]        fill_ff;
   logic [MAX_CHANNELS-1:0] sum_vld_ff;

   logic                    clr_busy_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;

   logic signed [SAMPLE_WIDTH-1:0] store_mem [STORE_DEPTH];
   logic signed [SUM_W-1:0]        sum_mem [MAX_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] store_rd_ff;
   logic signed [SUM_W-1:0]        sum_rd_ff;

   logic [ADDR_W-1:0]              store_addr;
   logic [ADDR_W-1:0]              store_addr_ff;
   logic [CIDX_W-1:0]              sum_addr;
   logic [CIDX_W-1:0]              sum_addr_ff;
   logic [CHANNEL_W-1:0]           chan_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           fend_ff;
   logic                           inuse_ff;
   logic                           full_ff;
   logic [WIN_W-1:0]               held_ff;
   logic                           full;

   logic signed [SUM_W-1:0]        sum_old;
   logic signed [SUM_W-1:0]        removed;
   logic signed [SUM_W-1:0]        new_sum;
   logic [SUM_W-1:0]               sum_mag;

   logic                           div_start;
   logic                           div_done;
   logic signed [SAMPLE_WIDTH-1:0] div_quot;

   logic                           rsp_valid_ff;
   logic [CHANNEL_W-1:0]           rsp_chan_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_avg_ff;
   logic                           rsp_fend_ff;

   logic accept;
   logic cfg_wr;
   logic rmw;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign csr_bus.ready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign cfg_wr        = csr_bus.valid && csr_bus.ready;
   assign rmw           = (state_ff == S_READ) && inuse_ff;

   always_comb begin
      if (win_cfg_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(win_cfg_ff) > MAX_WINDOW) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(win_cfg_ff);
      end
      if (chan_cfg_ff == '0) begin
         chan_eff = CHN_W'(1);
      end else if (32'(chan_cfg_ff) > MAX_CHANNELS) begin
         chan_eff = CHN_W'(MAX_CHANNELS);
      end else begin
         chan_eff = CHN_W'(chan_cfg_ff);
      end
   end

   assign store_addr = ADDR_W'(slot_ff) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(req_bus.channel);
   assign sum_addr   = CIDX_W'(req_bus.channel);
   assign full       = (fill_ff == win_eff);
   assign slot_plus  = WIN_W'(slot_ff) + WIN_W'(1);

   // Configuration and per-frame bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff  <= WINDOW_RESET;
         chan_cfg_ff <= CHAN_RESET;
         slot_ff     <= '0;
         fill_ff     <= '0;
         sum_vld_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (csr_reg_type'(csr_bus.index))
            REG_WINDOW_LENGTH: begin
               win_cfg_ff <= csr_bus.data[WINDOW_CFG_W-1:0];
               slot_ff    <= '0;
               fill_ff    <= '0;
               sum_vld_ff <= '0;
            end
            REG_CHANNELS_IN_USE: begin
               chan_cfg_ff <= csr_bus.data[CHAN_CFG_W-1:0];
               slot_ff     <= '0;
               fill_ff     <= '0;
               sum_vld_ff  <= '0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_READ) begin
         if (inuse_ff) begin
            sum_vld_ff[sum_addr_ff] <= 1'b1;
         end
         if (fend_ff) begin
            slot_ff <= (slot_plus >= win_eff) ? '0 : SLOT_W'(slot_plus);
            if (fill_ff < win_eff) begin
               fill_ff <= fill_ff + WIN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Captured item and the address it touches.
   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff       <= req_bus.channel;
         sample_ff     <= req_bus.sample;
         fend_ff       <= req_bus.frame_end;
         inuse_ff      <= (32'(req_bus.channel) < 32'(chan_eff));
         full_ff       <= full;
         held_ff       <= full ? win_eff : fill_ff + WIN_W'(1);
         store_addr_ff <= store_addr;
         sum_addr_ff   <= sum_addr;
      end
   end

   // Store and sums: read in the accept cycle, written back in the cycle after it (S_READ) when the channel is in use.
   always_ff @(posedge clock) begin
      store_rd_ff <= store_mem[store_addr];
      sum_rd_ff   <= sum_mem[sum_addr];
      if (clr_busy_ff) begin
         store_mem[clr_addr_ff] <= '0;
      end else if (rmw) begin
         store_mem[store_addr_ff] <= sample_ff;
      end
      if (rmw) begin
         sum_mem[sum_addr_ff] <= new_sum;
      end
   end

   assign sum_old   = sum_vld_ff[sum_addr_ff] ? sum_rd_ff : '0;
   assign removed   = full_ff ? SUM_W'(store_rd_ff) : '0;
   assign new_sum   = sum_old - removed + SUM_W'(sample_ff);
   assign sum_mag   = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
   assign div_start = rmw;

   mma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (WIN_W),
      .QUOTIENT_W (SAMPLE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .negate   (new_sum[SUM_W-1]),
      .dividend (sum_mag),
      .divisor  (held_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= inuse_ff ? S_DIV : S_OUT;
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_chan_ff  <= chan_ff;
                  rsp_avg_ff   <= inuse_ff ? div_quot : '0;
                  rsp_fend_ff  <= fend_ff;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_channel   = rsp_chan_ff;
   assign rsp_bus.average       = rsp_avg_ff;
   assign rsp_bus.out_frame_end = rsp_fend_ff;

   `MMA_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= win_eff, "fill count beyond window")
   `MMA_ASSERT_SAME(a_slot_bound, clock, reset, 1'b1, WIN_W'(slot_ff) < win_eff, "write slot beyond window")
   `MMA_ASSERT_NEXT(a_div_to_out, clock, reset, (state_ff == S_DIV) && div_done, state_ff == S_OUT, "divider result not taken")

endmodule

`default_nettype wire

// File: bench/multichannel_moving_average_unit_tb.sv
`timescale 1ns / 1ps

module multichannel_moving_average_unit_tb;
   import mma_pkg::*;

   localparam int SAMPLE_W        = 16;
   localparam int SUM_W           = 22;
   localparam int MAX_WIN         = 64;
   localparam int MAX_CH          = 8;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 25;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]       channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
   } sample_item_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]       out_channel;
      logic signed [SAMPLE_W-1:0] average;
      logic                       out_frame_end;
   } avg_result_type;

   logic clock = 1'b0;
   logic reset;

   mma_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_bus ();
   mma_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W)) rsp_bus ();
   mma_csr_if                            csr_bus ();

   multichannel_moving_average_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   sample_item_type sample_backlog[$];
   avg_result_type  expected_averages[$];
   int              error_count = 0;
   idle_mode_type   idle_mode = IDLE_NONE;
   logic            hold_request = 1'b0;

   // Predictor state.
   logic signed [SAMPLE_W-1:0] window_history [MAX_WIN][MAX_CH];
   logic signed [SUM_W-1:0]    channel_sums [MAX_CH];
   logic [5:0]                 history_slot;
   logic [6:0]                 frames_held;
   logic [WINDOW_CFG_W-1:0]    window_setting;
   logic [CHAN_CFG_W-1:0]      channel_setting;

   // Stimulus bookkeeping.
   int items_queued = 0;

   function automatic int effective_window(logic [WINDOW_CFG_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIN) return MAX_WIN;
      return w;
   endfunction

   function automatic int effective_channels(logic [CHAN_CFG_W-1:0] c);
      if (c == 0) return 1;
      if (c > MAX_CH) return MAX_CH;
      return c;
   endfunction

   function automatic void clear_averaging_history();
      foreach (window_history[s, c]) window_history[s][c] = '0;
      foreach (channel_sums[c]) channel_sums[c] = '0;
      history_slot = '0;
      frames_held = '0;
   endfunction

   function automatic void apply_register_write(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_WINDOW_LENGTH: begin
            window_setting = value[WINDOW_CFG_W-1:0];
            clear_averaging_history();
         end
         REG_CHANNELS_IN_USE: begin
            channel_setting = value[CHAN_CFG_W-1:0];
            clear_averaging_history();
         end
         default: ;
      endcase
   endfunction

   function automatic avg_result_type predict_average(sample_item_type item);
      int                      win;
      int                      nch;
      int                      held;
      logic signed [SUM_W-1:0] removed;
      logic signed [SUM_W-1:0] divisor;
      logic signed [SUM_W-1:0] quotient;
      avg_result_type          res;
      win = effective_window(window_setting);
      nch = effective_channels(channel_setting);
      if (history_slot >= win) history_slot = '0;
      if (frames_held > win) frames_held = 7'(win);
      quotient = '0;
      if (item.channel < nch) begin
         removed = '0;
         if (frames_held == win) removed = window_history[history_slot][item.channel];
         channel_sums[item.channel] = channel_sums[item.channel] - removed
                                      + $signed(item.sample);
         window_history[history_slot][item.channel] = item.sample;
         held = (frames_held == win) ? win : frames_held + 1;
         divisor = SUM_W'(held);
         quotient = channel_sums[item.channel] / divisor;
      end
      if (item.frame_end) begin
         history_slot = (history_slot + 1 >= win) ? 6'd0 : history_slot + 6'd1;
         if (frames_held < win) frames_held = frames_held + 7'd1;
      end
      res.out_channel   = item.channel;
      res.average       = quotient[SAMPLE_W-1:0];
      res.out_frame_end = item.frame_end;
      return res;
   endfunction

   function automatic bit sender_pauses();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 51;
         IDLE_BOTH:   return $urandom_range(99) < 15;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 51;
         IDLE_BOTH:     return $urandom_range(99) < 15;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Driver for the request channel.
   always @(posedge clock) begin
      sample_item_type next_item;
      logic            offer;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.channel   <= '0;
         req_bus.sample    <= '0;
         req_bus.frame_end <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         offer = 1'b0;
         if (sample_backlog.size() != 0 && !sender_pauses()) begin
            next_item = sample_backlog.pop_front();
            offer = 1'b1;
            req_bus.channel   <= next_item.channel;
            req_bus.sample    <= next_item.sample;
            req_bus.frame_end <= next_item.frame_end;
         end
         req_bus.valid <= offer;
      end
   end

   // Result channel back-pressure, including the long hold-off on request.
   logic hold_ack;
   int   hold_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_ack      <= 1'b0;
         hold_left     <= 0;
      end else if (hold_request != hold_ack) begin
         hold_ack      <= hold_request;
         hold_left     <= RSP_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !receiver_stalls();
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result and applies each register write.
   always @(posedge clock) begin
      avg_result_type got;
      avg_result_type want;
      if (reset) begin
         window_setting  = WINDOW_RESET;
         channel_setting = CHAN_RESET;
         clear_averaging_history();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_averages = {expected_averages, predict_average(
               '{req_bus.channel, req_bus.sample, req_bus.frame_end})};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_channel, rsp_bus.average, rsp_bus.out_frame_end};
            if (expected_averages.size() == 0) begin
               $error("Unexpected result transaction: out_channel %0d average %0d",
                      got.out_channel, got.average);
               error_count++;
            end else begin
               want = expected_averages.pop_front();
               if (got.out_channel !== want.out_channel) begin
                  $error("out_channel: expected %0d, actual %0d",
                         want.out_channel, got.out_channel);
                  error_count++;
               end
               if (got.average !== want.average) begin
                  $error("average: expected %0d, actual %0d", want.average, got.average);
                  error_count++;
               end
               if (got.out_frame_end !== want.out_frame_end) begin
                  $error("out_frame_end: expected %0d, actual %0d",
                         want.out_frame_end, got.out_frame_end);
                  error_count++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            apply_register_write(csr_reg_type'(csr_bus.index), csr_bus.data);
         end
      end
   end

   // Watchdog on cycles without any transaction.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("multichannel_moving_average_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_sample(input logic [CHANNEL_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] smp,
                               input logic fe);
      sample_backlog = {sample_backlog, sample_item_type'{ch, smp, fe}};
      items_queued++;
   endtask

   task automatic queue_full_frame(input int nch);
      for (int c = 0; c < nch; c++)
         queue_sample(CHANNEL_W'(c), random_sample(), c == nch - 1);
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (sample_backlog.size() != 0 || req_bus.valid || expected_averages.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] win_data,
                            input logic [CSR_DATA_W-1:0] ch_data);
      wait_until_drained();
      write_register(REG_WINDOW_LENGTH, win_data);
      write_register(REG_CHANNELS_IN_USE, ch_data);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] win_data,
                            input logic [CSR_DATA_W-1:0] ch_data,
                            input int count, input idle_mode_type mode,
                            input bit hold_receiver, input bit pause_midway);
      int       nch;
      int       first;
      int       last_ch;
      bit       paused;
      bit [7:0] present;
      configure(win_data, ch_data);
      nch = effective_channels(ch_data[CHAN_CFG_W-1:0]);
      first = items_queued;
      paused = 1'b0;
      @(posedge clock);
      idle_mode <= mode;
      if (hold_receiver) hold_request <= !hold_request;
      while (items_queued - first < count) begin
         if (pause_midway && !paused && items_queued - first >= count / 2) begin
            wait_until_drained();
            paused = 1'b1;
         end
         case ($urandom_range(3))
            0, 1: queue_full_frame(nch);
            2: begin
               present = 8'($urandom);
               last_ch = -1;
               for (int c = 0; c < nch; c++) if (present[c]) last_ch = c;
               for (int c = 0; c < nch; c++)
                  if (present[c]) queue_sample(CHANNEL_W'(c), random_sample(), c == last_ch);
               if (last_ch < 0)
                  queue_sample(CHANNEL_W'($urandom_range(MAX_CH - 1)), random_sample(), 1'b1);
            end
            default: queue_sample(CHANNEL_W'($urandom_range(MAX_CH - 1)), random_sample(),
                                  1'($urandom_range(1)));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.channel = '0;
      req_bus.sample = '0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_WINDOW_LENGTH;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // One complete frame at the reset configuration, with extreme samples.
      queue_sample(3'd0, 16'sh7FFF, 1'b0);
      queue_sample(3'd1, 16'sh8000, 1'b0);
      queue_sample(3'd2, 16'shFFFF, 1'b0);
      queue_sample(3'd3, 16'sh0000, 1'b0);
      queue_sample(3'd4, 16'sh0001, 1'b0);
      queue_sample(3'd5, 16'sh5555, 1'b0);
      queue_sample(3'd6, 16'shAAAA, 1'b0);
      queue_sample(3'd7, 16'sh7FFF, 1'b1);

      // Window of two over three channels: fill, then unused, skipped and
      // repeated channels and a frame closed by an unused channel.
      configure(8'd2, 8'd3);
      queue_sample(3'd0, 16'sh8000, 1'b0);
      queue_sample(3'd1, 16'sh7FFF, 1'b0);
      queue_sample(3'd2, 16'shFFFF, 1'b1);
      queue_sample(3'd0, 16'sh8000, 1'b0);
      queue_sample(3'd1, 16'sh7FFF, 1'b0);
      queue_sample(3'd2, 16'sh0001, 1'b1);
      queue_sample(3'd5, 16'sh1234, 1'b0);
      queue_sample(3'd0, 16'sh8000, 1'b0);
      queue_sample(3'd2, 16'sh8000, 1'b1);
      queue_sample(3'd1, 16'sh7FFF, 1'b0);
      queue_sample(3'd1, 16'sh7FFF, 1'b0);
      queue_sample(3'd7, 16'sh4321, 1'b1);
      queue_sample(3'd2, -16'sd5, 1'b1);

      run_phase(8'h00, 8'hFF, 120, IDLE_NONE,     1'b0, 1'b0);
      run_phase(8'd1,  8'd1,  60,  IDLE_SENDER,   1'b0, 1'b0);
      run_phase(8'd4,  8'd8,  150, IDLE_RECEIVER, 1'b0, 1'b0);
      run_phase(8'hFF, 8'd2,  200, IDLE_BOTH,     1'b0, 1'b0);
      run_phase(8'd64, 8'd0,  100, IDLE_NONE,     1'b1, 1'b0);
      run_phase(8'd3,  8'd5,  120, IDLE_SENDER,   1'b0, 1'b1);

      wait_until_drained();
      if (error_count == 0 && expected_averages.size() == 0) begin
         $display("multichannel_moving_average_unit_tb passed");
      end else begin
         if (expected_averages.size() != 0)
            $error("%0d expected results never arrived", expected_averages.size());
         $display("multichannel_moving_average_unit_tb failed");
      end
      $finish;
   end

endmodule
